FILE: sv/absc_pkg.sv
// ----------------------------------------------------------------------------
// absc_pkg
// Shared types, codes and constants of the A/B boot slot controller.
// ----------------------------------------------------------------------------
`default_nettype none

package absc_pkg;

  typedef logic [2:0]  func_t;
  typedef logic [1:0]  slot_t;
  typedef logic [3:0]  cnt_t;
  typedef logic [3:0]  reason_t;
  typedef logic [31:0] word_t;

  // Event codes.
  localparam func_t FUNC_SELECT   = 3'd0;
  localparam func_t FUNC_STAGE    = 3'd1;
  localparam func_t FUNC_ATTEMPT  = 3'd2;
  localparam func_t FUNC_CONFIRM  = 3'd3;
  localparam func_t FUNC_ROLLBACK = 3'd4;
  localparam func_t FUNC_CLEAR    = 3'd5;

  // Slot codes.
  localparam slot_t SLOT_NONE    = 2'd0;
  localparam slot_t SLOT_A       = 2'd1;
  localparam slot_t SLOT_B       = 2'd2;
  localparam slot_t SLOT_UNKNOWN = 2'd3;

  // Configuration register indexes.
  localparam logic REG_MAX_ATTEMPTS  = 1'b0;
  localparam logic REG_SLOT_CAPACITY = 1'b1;

  // Attempt limits and reset values.
  localparam cnt_t  ATTEMPT_LIMIT_TOP = 4'd10;
  localparam cnt_t  ATTEMPT_DEFAULT   = 4'd3;
  localparam cnt_t  ATTEMPT_SAT       = 4'd15;
  localparam cnt_t  CNT_ONE           = 4'd1;
  localparam word_t CAPACITY_DEFAULT  = 32'd1048576;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // apply the event to the boot record
    logic load;     // fill the result register
  } absc_cmd_t;

endpackage

`default_nettype wire

FILE: sv/absc_if.sv
// ----------------------------------------------------------------------------
// absc_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface absc_in_if
  import absc_pkg::*;
;
  logic    valid;
  logic    ready;
  func_t   func;
  slot_t   slot;
  word_t   image_bytes;
  word_t   image_checksum;
  reason_t reason;

  modport source (output valid, func, slot, image_bytes, image_checksum, reason,
                  input ready);
  modport sink   (input valid, func, slot, image_bytes, image_checksum, reason,
                  output ready);
endinterface

interface absc_out_if
  import absc_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    ok;
  slot_t   boot_slot;
  slot_t   active_out;
  slot_t   confirmed_out;
  slot_t   pending_out;
  slot_t   last_boot_out;
  reason_t reason_out;
  cnt_t    slot_attempts;
  word_t   slot_checksum_out;

  modport source (output valid, ok, boot_slot, active_out, confirmed_out,
                  pending_out, last_boot_out, reason_out, slot_attempts,
                  slot_checksum_out,
                  input ready);
  modport sink   (input valid, ok, boot_slot, active_out, confirmed_out,
                  pending_out, last_boot_out, reason_out, slot_attempts,
                  slot_checksum_out,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/absc_ctrl.sv
// ----------------------------------------------------------------------------
// absc_ctrl
// Sequencer: capture an item, apply it, load the result, hand it over.
// ----------------------------------------------------------------------------
`default_nettype none

module absc_ctrl
  import absc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output absc_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Handshake outputs decode straight from the state.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/absc_dp.sv
// ----------------------------------------------------------------------------
// absc_dp
// Boot record, configuration registers, event update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module absc_dp
  import absc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  absc_cmd_t    cmd,
  input  wire func_t   in_func,
  input  wire slot_t   in_slot,
  input  wire word_t   in_image_bytes,
  input  wire word_t   in_image_checksum,
  input  wire reason_t in_reason,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire word_t   cfg_wdata,
  output logic         out_ok,
  output slot_t        out_boot_slot,
  output slot_t        out_active,
  output slot_t        out_confirmed,
  output slot_t        out_pending,
  output slot_t        out_last_boot,
  output reason_t      out_reason,
  output cnt_t         out_slot_attempts,
  output word_t        out_slot_checksum
);

  // Configuration registers.
  cnt_t    max_att_r, max_att_nxt;
  word_t   capacity_r;

  // Boot record.
  logic    valid_r [2];
  word_t   size_r  [2];
  word_t   csum_r  [2];
  cnt_t    cnt_r   [2];
  slot_t   act_r, conf_r, pend_r, last_r;
  reason_t rsn_r;

  logic    valid_nxt [2];
  word_t   size_nxt  [2];
  word_t   csum_nxt  [2];
  cnt_t    cnt_nxt   [2];
  slot_t   act_nxt, conf_nxt, pend_nxt, last_nxt;
  reason_t rsn_nxt;
  logic    ok_nxt;

  // Latched item.
  func_t   func_r;
  slot_t   slot_r;
  word_t   isize_r;
  word_t   icsum_r;
  reason_t irsn_r;
  logic    ok_r;

  // Sanitized view of the record.
  logic    boot   [2];
  logic    s_valid[2];
  word_t   s_size [2];
  word_t   s_csum [2];
  cnt_t    s_cnt  [2];
  cnt_t    s_max;
  slot_t   s_act, s_conf, s_pend, s_last;

  logic    known;
  logic    idx;
  logic    tgt_boot;
  logic    fits_in;
  cnt_t    tgt_cnt;

  // Selection terms.
  logic    pend_ok;
  slot_t   act_pick;
  logic    act_boot;
  slot_t   boot_pick;

  function automatic logic slot_is_known(slot_t s);
    return (s == SLOT_A) || (s == SLOT_B);
  endfunction

  // Which slots can be booted right now.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      boot[i] = valid_r[i] && (size_r[i] != '0) && (size_r[i] <= capacity_r);
    end
  end

  // Sanitized record, used by stage and rollback.
  always_comb begin
    s_max = ((max_att_r == '0) || (max_att_r > ATTEMPT_LIMIT_TOP)) ?
            ATTEMPT_DEFAULT : max_att_r;
    for (int i = 0; i < 2; i++) begin
      s_valid[i] = boot[i] ? valid_r[i] : 1'b0;
      s_size[i]  = ((size_r[i] != '0) && (size_r[i] <= capacity_r)) ? size_r[i] : '0;
      s_csum[i]  = boot[i] ? csum_r[i] : '0;
      s_cnt[i]   = boot[i] ? cnt_r[i] : '0;
      if (s_cnt[i] > s_max) begin
        s_cnt[i] = s_max;
      end
    end
    s_act  = (((act_r == SLOT_A) && boot[0]) || ((act_r == SLOT_B) && boot[1])) ?
             act_r : SLOT_NONE;
    s_conf = (((conf_r == SLOT_A) && boot[0]) || ((conf_r == SLOT_B) && boot[1])) ?
             conf_r : SLOT_NONE;
    s_pend = (((pend_r == SLOT_A) && boot[0]) || ((pend_r == SLOT_B) && boot[1])) ?
             pend_r : SLOT_NONE;
    s_last = slot_is_known(last_r) ? last_r : SLOT_NONE;
    if ((s_act == SLOT_NONE) && (s_conf != SLOT_NONE)) begin
      s_act = s_conf;
    end
  end

  // Event update.
  always_comb begin
    known    = slot_is_known(slot_r);
    idx      = (slot_r == SLOT_B);
    tgt_boot = known && (idx ? boot[1] : boot[0]);
    tgt_cnt  = idx ? cnt_r[1] : cnt_r[0];
    fits_in  = (isize_r != '0) && (isize_r <= capacity_r);

    max_att_nxt = max_att_r;
    for (int i = 0; i < 2; i++) begin
      valid_nxt[i] = valid_r[i];
      size_nxt[i]  = size_r[i];
      csum_nxt[i]  = csum_r[i];
      cnt_nxt[i]   = cnt_r[i];
    end
    act_nxt  = act_r;
    conf_nxt = conf_r;
    pend_nxt = pend_r;
    last_nxt = last_r;
    rsn_nxt  = rsn_r;
    ok_nxt   = 1'b0;

    case (func_r)
      FUNC_SELECT: begin
        ok_nxt = 1'b1;
      end
      FUNC_STAGE: begin
        if (known && fits_in) begin
          max_att_nxt = s_max;
          for (int i = 0; i < 2; i++) begin
            valid_nxt[i] = s_valid[i];
            size_nxt[i]  = s_size[i];
            csum_nxt[i]  = s_csum[i];
            cnt_nxt[i]   = s_cnt[i];
          end
          valid_nxt[idx] = 1'b1;
          size_nxt[idx]  = isize_r;
          csum_nxt[idx]  = icsum_r;
          cnt_nxt[idx]   = '0;
          act_nxt  = s_act;
          conf_nxt = s_conf;
          pend_nxt = slot_r;
          last_nxt = s_last;
          rsn_nxt  = '0;
          ok_nxt   = 1'b1;
        end
      end
      FUNC_ATTEMPT: begin
        if (tgt_boot) begin
          cnt_nxt[idx] = (tgt_cnt == ATTEMPT_SAT) ? ATTEMPT_SAT : (tgt_cnt + CNT_ONE);
          last_nxt     = slot_r;
          ok_nxt       = 1'b1;
        end
      end
      FUNC_CONFIRM: begin
        if (tgt_boot) begin
          cnt_nxt[idx] = '0;
          act_nxt  = slot_r;
          conf_nxt = slot_r;
          pend_nxt = SLOT_NONE;
          last_nxt = slot_r;
          rsn_nxt  = '0;
          ok_nxt   = 1'b1;
        end
      end
      FUNC_ROLLBACK: begin
        max_att_nxt = s_max;
        for (int i = 0; i < 2; i++) begin
          valid_nxt[i] = s_valid[i];
          size_nxt[i]  = s_size[i];
          csum_nxt[i]  = s_csum[i];
          cnt_nxt[i]   = s_cnt[i];
        end
        pend_nxt = SLOT_NONE;
        last_nxt = s_last;
        rsn_nxt  = irsn_r;
        conf_nxt = s_conf;
        // Sanitizing keeps bootable slots bootable, so the old check holds.
        if (tgt_boot) begin
          act_nxt = slot_r;
          if (s_conf == SLOT_NONE) begin
            conf_nxt = slot_r;
          end
        end else begin
          act_nxt = SLOT_NONE;
        end
        ok_nxt = 1'b1;
      end
      FUNC_CLEAR: begin
        if (known) begin
          valid_nxt[idx] = 1'b0;
          size_nxt[idx]  = '0;
          csum_nxt[idx]  = '0;
          cnt_nxt[idx]   = '0;
          if (act_r == slot_r) begin
            act_nxt = SLOT_NONE;
          end
          if (pend_r == slot_r) begin
            pend_nxt = SLOT_NONE;
          end
          if (conf_r == slot_r) begin
            conf_nxt = SLOT_NONE;
          end
          if (last_r == slot_r) begin
            last_nxt = SLOT_NONE;
          end
          ok_nxt = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Boot choice from the updated record.
  always_comb begin
    pend_ok = ((pend_r == SLOT_A) && boot[0] && (cnt_r[0] < max_att_r)) ||
              ((pend_r == SLOT_B) && boot[1] && (cnt_r[1] < max_att_r));
    if (slot_is_known(act_r)) begin
      act_pick = act_r;
    end else if (slot_is_known(conf_r)) begin
      act_pick = conf_r;
    end else begin
      act_pick = SLOT_NONE;
    end
    act_boot = ((act_pick == SLOT_A) && boot[0]) || ((act_pick == SLOT_B) && boot[1]);
    if (pend_ok) begin
      boot_pick = pend_r;
    end else if (act_boot) begin
      boot_pick = act_pick;
    end else if (boot[0]) begin
      boot_pick = SLOT_A;
    end else if (boot[1]) begin
      boot_pick = SLOT_B;
    end else begin
      boot_pick = SLOT_NONE;
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      slot_r  <= in_slot;
      isize_r <= in_image_bytes;
      icsum_r <= in_image_checksum;
      irsn_r  <= in_reason;
    end
  end

  // Record and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_att_r  <= ATTEMPT_DEFAULT;
      capacity_r <= CAPACITY_DEFAULT;
      for (int i = 0; i < 2; i++) begin
        valid_r[i] <= 1'b0;
        size_r[i]  <= '0;
        csum_r[i]  <= '0;
        cnt_r[i]   <= '0;
      end
      act_r  <= SLOT_NONE;
      conf_r <= SLOT_NONE;
      pend_r <= SLOT_NONE;
      last_r <= SLOT_NONE;
      rsn_r  <= '0;
      ok_r   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        max_att_r <= max_att_nxt;
        for (int i = 0; i < 2; i++) begin
          valid_r[i] <= valid_nxt[i];
          size_r[i]  <= size_nxt[i];
          csum_r[i]  <= csum_nxt[i];
          cnt_r[i]   <= cnt_nxt[i];
        end
        act_r  <= act_nxt;
        conf_r <= conf_nxt;
        pend_r <= pend_nxt;
        last_r <= last_nxt;
        rsn_r  <= rsn_nxt;
        ok_r   <= ok_nxt;
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAX_ATTEMPTS) begin
          max_att_r <= cfg_wdata[3:0];
        end else begin
          capacity_r <= cfg_wdata;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ok            <= ok_r;
      out_boot_slot     <= boot_pick;
      out_active        <= act_r;
      out_confirmed     <= conf_r;
      out_pending       <= pend_r;
      out_last_boot     <= last_r;
      out_reason        <= rsn_r;
      out_slot_attempts <= (slot_r == SLOT_A) ? cnt_r[0] :
                           (slot_r == SLOT_B) ? cnt_r[1] : '0;
      out_slot_checksum <= (slot_r == SLOT_A) ? csum_r[0] :
                           (slot_r == SLOT_B) ? csum_r[1] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ab_boot_slot_controller.sv
// ----------------------------------------------------------------------------
// ab_boot_slot_controller
// A/B firmware slot boot record with staging, confirmation and rollback.
//
// Events arrive as items on the in_if valid/ready channel; each event yields
// exactly one result item on out_if, carrying the accept flag, the slot to
// boot and the record after the event. Configuration (max_attempts at index
// 0, slot_capacity at index 1) is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while no event is in flight, as the block
// itself does not enforce this. One item is handled at a time: in_ready is
// high only while the block is idle. After acceptance the event is applied
// in the next cycle, the result register is loaded in the one after, and
// out_if.valid then rises with the loaded result. Each item passes through
// the capture, update, load and hand-over steps of the sequencer. When the
// receiver stalls, the result holds steady and no new event is taken until
// it is accepted.
// Reset (synchronous, active low) clears the record to all slots empty and
// restores max_attempts to 3 and slot_capacity to 1048576.
// ----------------------------------------------------------------------------
`default_nettype none

module ab_boot_slot_controller
  import absc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  absc_in_if.sink     in_if,
  absc_out_if.source  out_if,
  input  wire logic   cfg_we,
  input  wire logic   cfg_index,
  input  wire word_t  cfg_wdata
);

  absc_cmd_t cmd;

  absc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  absc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_if.func),
    .in_slot           (in_if.slot),
    .in_image_bytes    (in_if.image_bytes),
    .in_image_checksum (in_if.image_checksum),
    .in_reason         (in_if.reason),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ok            (out_if.ok),
    .out_boot_slot     (out_if.boot_slot),
    .out_active        (out_if.active_out),
    .out_confirmed     (out_if.confirmed_out),
    .out_pending       (out_if.pending_out),
    .out_last_boot     (out_if.last_boot_out),
    .out_reason        (out_if.reason_out),
    .out_slot_attempts (out_if.slot_attempts),
    .out_slot_checksum (out_if.slot_checksum_out)
  );

endmodule

`default_nettype wire
